>>> design/cco_pkg.sv
// Shared constants for the capsule-versus-circle overlap pipeline.
// Holds field widths, derived arithmetic widths and the region codes.
// Has no dependencies.
package cco_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 4;

  localparam int NUM_FIELDS  = 8;
  localparam int IN_DATA_W   = ((NUM_FIELDS * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SQ_W    = PROD_W;
  localparam int SPLIT_W = DIFF_W;
  localparam int HI_W    = SUM_W - SPLIT_W;
  localparam int FHI_W   = SQ_W - SPLIT_W;
  localparam int PART_W  = SUM_W + SPLIT_W + 1;
  localparam int QPART_W = SQ_W + SPLIT_W;
  localparam int CMP_W   = 2 * SQ_W + 2;

  typedef logic [1:0] region_t;

  localparam region_t REGION_START    = 2'd0;
  localparam region_t REGION_END      = 2'd1;
  localparam region_t REGION_INTERIOR = 2'd2;

endpackage

>>> design/capsule_circle_overlap.sv
// Capsule-versus-circle overlap test, six register stages, one request per unstalled cycle.
// Depends on cco_pkg for widths and region codes.
//
// Channel | Direction | Contents
// in_     | input     | segment start and end, capsule radius, circle center and radius
// out_    | output    | overlap flag and nearest region
//
// A request passes through stages 1 to 5 and the output register; a new request is taken
// every cycle in which the output register is empty or being taken.
// The two wide products of the interior test are split into half-width partial products
// over two stages, which sets the depth of the pipeline.
// Reset clears every stage valid bit; payload registers are not reset.
// All stages advance together whenever the output register is empty or being taken.
module capsule_circle_overlap (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, capsule_radius,
  // circle_center_x, circle_center_y, circle_radius
  input  logic [cco_pkg::IN_DATA_W-1:0] in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // overlap, nearest_region, zero fill
  output logic [cco_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int CB  = cco_pkg::COORD_BITS;
  localparam int DW  = cco_pkg::DIFF_W;
  localparam int PW  = cco_pkg::PROD_W;
  localparam int SW  = cco_pkg::SUM_W;
  localparam int QW  = cco_pkg::SQ_W;
  localparam int SPW = cco_pkg::SPLIT_W;
  localparam int HW  = cco_pkg::HI_W;
  localparam int FHW = cco_pkg::FHI_W;
  localparam int PAW = cco_pkg::PART_W;
  localparam int QPW = cco_pkg::QPART_W;
  localparam int CW  = cco_pkg::CMP_W;

  logic adv;

  logic signed [CB-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
  logic signed [CB-1:0] circle_center_x, circle_center_y;
  logic        [CB-1:0] capsule_radius, circle_radius;

  assign seg_start_x     = in_tdata[0*CB +: CB];
  assign seg_start_y     = in_tdata[1*CB +: CB];
  assign seg_end_x       = in_tdata[2*CB +: CB];
  assign seg_end_y       = in_tdata[3*CB +: CB];
  assign capsule_radius  = in_tdata[4*CB +: CB];
  assign circle_center_x = in_tdata[5*CB +: CB];
  assign circle_center_y = in_tdata[6*CB +: CB];
  assign circle_radius   = in_tdata[7*CB +: CB];

  logic out_valid_r;
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Stage 1: coordinate differences and radius sum.
  logic                 s1_valid_r;
  logic signed [DW-1:0] s1_abx_r, s1_aby_r, s1_acx_r, s1_acy_r, s1_bcx_r, s1_bcy_r;
  logic        [DW-1:0] s1_rsum_r;

  // Stage 2: products.
  logic                 s2_valid_r;
  logic signed [PW-1:0] s2_abxx_r, s2_abyy_r, s2_ex_r, s2_ey_r;
  logic signed [PW-1:0] s2_acxx_r, s2_acyy_r, s2_bcxx_r, s2_bcyy_r;
  logic signed [PW-1:0] s2_cx_r, s2_cy_r;
  logic        [QW-1:0] s2_rsq_r;

  // Stage 3: dot products, squared lengths and cross product.
  logic                 s3_valid_r;
  logic signed [SW-1:0] s3_e_r, s3_f_r, s3_ac2_r, s3_bc2_r, s3_cross_r;
  logic        [QW-1:0] s3_rsq_r;

  // Stage 4: region, endpoint tests and partial products.
  logic                  s4_valid_r;
  cco_pkg::region_t      s4_region_r;
  logic                  s4_hit_start_r, s4_hit_end_r;
  logic signed [PAW-1:0] s4_c0_r, s4_c1_r;
  logic        [QPW-1:0] s4_q0_r, s4_q1_r;

  // Stage 5: partial product sums.
  logic                 s5_valid_r;
  cco_pkg::region_t     s5_region_r;
  logic                 s5_hit_start_r, s5_hit_end_r;
  logic signed [CW-1:0] s5_cross2_r, s5_rhs_r;

  // Output register.
  cco_pkg::region_t out_region_r;
  logic             out_overlap_r;

  logic signed [SPW:0]    s3_cross_lo;
  logic signed [HW-1:0]   s3_cross_hi;
  logic        [SPW-1:0]  s3_f_lo;
  logic        [FHW-1:0]  s3_f_hi;
  logic                   s3_e_le_zero, s3_f_le_e;
  cco_pkg::region_t       s4_region_nxt;
  logic                   out_overlap_nxt;

  assign s3_cross_lo  = $signed({1'b0, s3_cross_r[SPW-1:0]});
  assign s3_cross_hi  = s3_cross_r[SW-1:SPW];
  assign s3_f_lo      = s3_f_r[SPW-1:0];
  assign s3_f_hi      = s3_f_r[QW-1:SPW];
  assign s3_e_le_zero = s3_e_r[SW-1] || (s3_e_r == '0);
  assign s3_f_le_e    = (s3_f_r <= s3_e_r);

  always_comb begin
    priority if (s3_e_le_zero) begin
      s4_region_nxt = cco_pkg::REGION_START;
    end else if (s3_f_le_e) begin
      s4_region_nxt = cco_pkg::REGION_END;
    end else begin
      s4_region_nxt = cco_pkg::REGION_INTERIOR;
    end
  end

  always_comb begin
    unique case (s5_region_r)
      cco_pkg::REGION_START: out_overlap_nxt = s5_hit_start_r;
      cco_pkg::REGION_END:   out_overlap_nxt = s5_hit_end_r;
      default:               out_overlap_nxt = (s5_cross2_r <= s5_rhs_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      s5_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= in_tvalid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      s5_valid_r  <= s4_valid_r;
      out_valid_r <= s5_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_abx_r  <= DW'(seg_end_x) - DW'(seg_start_x);
      s1_aby_r  <= DW'(seg_end_y) - DW'(seg_start_y);
      s1_acx_r  <= DW'(circle_center_x) - DW'(seg_start_x);
      s1_acy_r  <= DW'(circle_center_y) - DW'(seg_start_y);
      s1_bcx_r  <= DW'(circle_center_x) - DW'(seg_end_x);
      s1_bcy_r  <= DW'(circle_center_y) - DW'(seg_end_y);
      s1_rsum_r <= DW'(capsule_radius) + DW'(circle_radius);

      s2_abxx_r <= PW'(s1_abx_r) * PW'(s1_abx_r);
      s2_abyy_r <= PW'(s1_aby_r) * PW'(s1_aby_r);
      s2_ex_r   <= PW'(s1_acx_r) * PW'(s1_abx_r);
      s2_ey_r   <= PW'(s1_acy_r) * PW'(s1_aby_r);
      s2_acxx_r <= PW'(s1_acx_r) * PW'(s1_acx_r);
      s2_acyy_r <= PW'(s1_acy_r) * PW'(s1_acy_r);
      s2_bcxx_r <= PW'(s1_bcx_r) * PW'(s1_bcx_r);
      s2_bcyy_r <= PW'(s1_bcy_r) * PW'(s1_bcy_r);
      s2_cx_r   <= PW'(s1_acx_r) * PW'(s1_aby_r);
      s2_cy_r   <= PW'(s1_acy_r) * PW'(s1_abx_r);
      s2_rsq_r  <= QW'(s1_rsum_r) * QW'(s1_rsum_r);

      s3_e_r     <= SW'(s2_ex_r) + SW'(s2_ey_r);
      s3_f_r     <= SW'(s2_abxx_r) + SW'(s2_abyy_r);
      s3_ac2_r   <= SW'(s2_acxx_r) + SW'(s2_acyy_r);
      s3_bc2_r   <= SW'(s2_bcxx_r) + SW'(s2_bcyy_r);
      s3_cross_r <= SW'(s2_cx_r) - SW'(s2_cy_r);
      s3_rsq_r   <= s2_rsq_r;

      s4_region_r    <= s4_region_nxt;
      s4_hit_start_r <= (s3_ac2_r[QW-1:0] <= s3_rsq_r);
      s4_hit_end_r   <= (s3_bc2_r[QW-1:0] <= s3_rsq_r);
      s4_c0_r        <= PAW'(s3_cross_r) * PAW'(s3_cross_lo);
      s4_c1_r        <= PAW'(s3_cross_r) * PAW'(s3_cross_hi);
      s4_q0_r        <= QPW'(s3_rsq_r) * QPW'(s3_f_lo);
      s4_q1_r        <= QPW'(s3_rsq_r) * QPW'(s3_f_hi);

      s5_region_r    <= s4_region_r;
      s5_hit_start_r <= s4_hit_start_r;
      s5_hit_end_r   <= s4_hit_end_r;
      s5_cross2_r    <= CW'(s4_c0_r) + (CW'(s4_c1_r) <<< SPW);
      s5_rhs_r       <= $signed(CW'(s4_q0_r) + (CW'(s4_q1_r) << SPW));

      out_region_r  <= s5_region_r;
      out_overlap_r <= out_overlap_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(cco_pkg::OUT_DATA_W - 3)'(0), out_region_r, out_overlap_r};

`ifndef SYNTH
  a_degenerate_start: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_valid_r && s3_f_r == '0) |=> (s4_region_r == cco_pkg::REGION_START))
    else $error("degenerate segment did not take the start region");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && s3_valid_r) |=> ($stable(s3_e_r) && $stable(s3_cross_r) && s3_valid_r))
    else $error("pipeline stage changed during a stall");

  a_interior_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s3_valid_r && s4_region_nxt == cco_pkg::REGION_INTERIOR)
      |=> (s4_q0_r != '0 || s4_q1_r != '0 || $past(s3_rsq_r) == '0))
    else $error("interior region reached with an empty segment");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
